>>> rtl/espw_pkg.sv
// Shared types, codes and the priority search for the event slot pool.
// No dependencies; used by the top level and the port checker.
package espw_pkg;

	// item from the requester
	typedef struct packed {
		logic [2:0] func;
		logic [3:0] event_slot;
		logic [5:0] task_prio;
	} cmd_t;

	// item back to the requester
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_out;
		logic [5:0] prio_out;
	} rsp_t;

	localparam logic [2:0] FN_ALLOC  = 3'd0;
	localparam logic [2:0] FN_FREE   = 3'd1;
	localparam logic [2:0] FN_PEND   = 3'd2;
	localparam logic [2:0] FN_REMOVE = 3'd3;
	localparam logic [2:0] FN_READY  = 3'd4;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_MISS      = 2'd1;
	localparam logic [1:0] STAT_NOT_ALLOC = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Highest set bit of a 64-bit set, as {found, index}.
	// Two passes of eight: pick the top nonempty byte, then the top bit in it.
	function automatic logic [6:0] msb_find(input logic [63:0] v);
		logic [7:0] grp;
		logic [7:0] sel;
		logic [2:0] g;
		logic [2:0] b;
		for (int i = 0; i < 8; i++) begin
			grp[i] = |v[i*8 +: 8];
		end
		g = '0;
		for (int i = 0; i < 8; i++) begin
			if (grp[i]) g = 3'(i);
		end
		sel = v[g*8 +: 8];
		b = '0;
		for (int i = 0; i < 8; i++) begin
			if (sel[i]) b = 3'(i);
		end
		return {|grp, g, b};
	endfunction

endpackage

>>> rtl/espw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module espw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

>>> rtl/event_slot_pool_with_priority_waitlists.sv
// Event slot pool with LIFO free list and per-slot priority wait sets.
// Uses espw_pkg (types, codes, msb_find) and espw_ram (wait sets, free links).
//
//  channel | dir | payload | handshake
//  cmd     | in  | cmd_t   | cmd_valid / cmd_ready
//  rsp     | out | rsp_t   | rsp_valid / rsp_ready
//
// Each item is accepted in S_IDLE, which also issues the RAM reads; in S_EXEC it is
// modified, written back and loaded into the response register.
// Reset is immediate: link entries never written read as i+1, no clear pass.
// A new item is taken while the previous response still waits; the execute
// cycle holds until the response register is free.
module event_slot_pool_with_priority_waitlists #(
	parameter int EVENT_SLOTS = 16,
	parameter int PRIO_LEVELS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  espw_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output espw_pkg::rsp_t  rsp
);

	localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int TOP_W  = $clog2(EVENT_SLOTS + 1);
	localparam int PRIO_W = $clog2(PRIO_LEVELS);
	localparam int CW     = (SLOT_W > 4) ? SLOT_W : 4;

	espw_pkg::state_t state_q, state_d;
	espw_pkg::cmd_t   cmd_s1;
	espw_pkg::rsp_t   rsp_q, rsp_d;
	logic             rsp_valid_q;

	logic [TOP_W-1:0]       free_top_q, free_top_d;
	logic [EVENT_SLOTS-1:0] in_use_q, in_use_d;
	logic [EVENT_SLOTS-1:0] link_vld_q, link_vld_d;

	// RAM ports
	logic                   ws_we, ws_re;
	logic [SLOT_W-1:0]      ws_waddr, ws_raddr;
	logic [PRIO_LEVELS-1:0] ws_wdata, ws_rdata;
	logic                   lk_we;
	logic [SLOT_W-1:0]      lk_waddr;
	logic [TOP_W-1:0]       lk_wdata, lk_rdata;

	logic              accept, fire;
	logic [CW-1:0]     in_slot_ext, slot_ext, top_ext;
	logic [SLOT_W-1:0] slot_idx, top_idx;
	logic              slot_ok, prio_in_rng, pool_empty;
	logic [PRIO_W-1:0] prio_idx, found_idx;
	logic [TOP_W-1:0]  link_next;
	logic [6:0]        found;
	logic [PRIO_LEVELS-1:0] prio_mask, found_mask;

	assign cmd_ready = (state_q == espw_pkg::S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign fire      = (state_q == espw_pkg::S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// read addresses are issued in the accept cycle
	assign in_slot_ext = CW'(cmd.event_slot);
	assign ws_raddr    = in_slot_ext[SLOT_W-1:0];
	assign ws_re       = accept;

	espw_ram #(.WIDTH(PRIO_LEVELS), .DEPTH(EVENT_SLOTS)) u_ws_ram (
		.clk   (clk),
		.we    (ws_we),
		.waddr (ws_waddr),
		.wdata (ws_wdata),
		.re    (ws_re),
		.raddr (ws_raddr),
		.rdata (ws_rdata)
	);

	espw_ram #(.WIDTH(TOP_W), .DEPTH(EVENT_SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (accept),
		.raddr (top_idx),
		.rdata (lk_rdata)
	);

	assign slot_ext    = CW'(cmd_s1.event_slot);
	assign slot_idx    = slot_ext[SLOT_W-1:0];
	assign slot_ok     = (32'(cmd_s1.event_slot) < EVENT_SLOTS) && in_use_q[slot_idx];
	assign prio_in_rng = 32'(cmd_s1.task_prio) < PRIO_LEVELS;
	assign prio_idx    = cmd_s1.task_prio[PRIO_W-1:0];
	assign pool_empty  = free_top_q >= TOP_W'(EVENT_SLOTS);
	assign top_idx     = free_top_q[SLOT_W-1:0];
	assign top_ext     = CW'(top_idx);
	// a link never written since reset is taken as i+1 in place of the RAM data
	assign link_next   = link_vld_q[top_idx] ? lk_rdata : free_top_q + TOP_W'(1);
	assign found       = espw_pkg::msb_find(64'(ws_rdata));
	assign found_idx   = found[PRIO_W-1:0];

	always_comb begin
		prio_mask = '0;
		prio_mask[prio_idx] = 1'b1;
		found_mask = '0;
		found_mask[found_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= espw_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			free_top_q  <= '0;
			in_use_q    <= '0;
			link_vld_q  <= '0;
		end else begin
			state_q    <= state_d;
			free_top_q <= free_top_d;
			in_use_q   <= in_use_d;
			link_vld_q <= link_vld_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd_s1 <= cmd;
		if (fire) rsp_q <= rsp_d;
	end

	always_comb begin
		state_d    = state_q;
		free_top_d = free_top_q;
		in_use_d   = in_use_q;
		link_vld_d = link_vld_q;
		ws_we      = 1'b0;
		ws_waddr   = slot_idx;
		ws_wdata   = '0;
		lk_we      = 1'b0;
		lk_waddr   = slot_idx;
		lk_wdata   = free_top_q;
		rsp_d.status   = espw_pkg::STAT_OK;
		rsp_d.slot_out = cmd_s1.event_slot;
		rsp_d.prio_out = '0;

		unique case (state_q)
			espw_pkg::S_IDLE: begin
				if (accept) state_d = espw_pkg::S_EXEC;
			end
			espw_pkg::S_EXEC: begin
				case (cmd_s1.func)
					espw_pkg::FN_ALLOC: begin
						if (pool_empty) begin
							rsp_d.status   = espw_pkg::STAT_MISS;
							rsp_d.slot_out = '0;
						end else begin
							ws_we              = fire;
							ws_waddr           = top_idx;
							in_use_d[top_idx]  = in_use_q[top_idx] | fire;
							rsp_d.slot_out     = top_ext[3:0];
							if (fire) free_top_d = link_next;
						end
					end
					espw_pkg::FN_FREE: begin
						if (!slot_ok) begin
							rsp_d.status = espw_pkg::STAT_NOT_ALLOC;
						end else begin
							ws_we = fire;
							lk_we = fire;
							if (fire) begin
								in_use_d[slot_idx]   = 1'b0;
								link_vld_d[slot_idx] = 1'b1;
								free_top_d           = TOP_W'(slot_idx);
							end
						end
					end
					espw_pkg::FN_PEND: begin
						if (!slot_ok) begin
							rsp_d.status = espw_pkg::STAT_NOT_ALLOC;
						end else if (!prio_in_rng) begin
							rsp_d.status = espw_pkg::STAT_MISS;
						end else begin
							ws_we    = fire;
							ws_wdata = ws_rdata | prio_mask;
						end
					end
					espw_pkg::FN_REMOVE: begin
						if (!slot_ok) begin
							rsp_d.status = espw_pkg::STAT_NOT_ALLOC;
						end else if (!prio_in_rng || !(|(ws_rdata & prio_mask))) begin
							rsp_d.status = espw_pkg::STAT_MISS;
						end else begin
							ws_we    = fire;
							ws_wdata = ws_rdata & ~prio_mask;
						end
					end
					espw_pkg::FN_READY: begin
						if (!slot_ok) begin
							rsp_d.status = espw_pkg::STAT_NOT_ALLOC;
						end else if (!found[6]) begin
							rsp_d.status = espw_pkg::STAT_MISS;
						end else begin
							ws_we          = fire;
							ws_wdata       = ws_rdata & ~found_mask;
							rsp_d.prio_out = 6'(found_idx);
						end
					end
					default: begin
						// unused codes: no-op, echo slot
					end
				endcase
				if (fire) state_d = espw_pkg::S_IDLE;
			end
			default: state_d = espw_pkg::S_IDLE;
		endcase
	end

endmodule

>>> rtl/espw_checker.sv
// Port-level checks for the event slot pool, bound to the top level.
// Uses espw_pkg for the payload types and status codes.
module espw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input espw_pkg::cmd_t cmd,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input espw_pkg::rsp_t rsp
);

	// a command waiting for ready stays put
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("command dropped or changed while waiting");

	// a held response keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one item in flight: busy the cycle after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one executes");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == espw_pkg::STAT_OK ||
			rsp.status == espw_pkg::STAT_MISS ||
			rsp.status == espw_pkg::STAT_NOT_ALLOC))
		else $error("undefined status code");

	// a priority is only returned on success
	a_prio_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != espw_pkg::STAT_OK |-> rsp.prio_out == '0)
		else $error("priority reported with failing status");

endmodule

bind event_slot_pool_with_priority_waitlists espw_checker u_espw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

>>> verif/espw_pool_check.sv
`timescale 1ns / 100ps
// Response checker for the event slot pool: watches both channels, keeps its own
// slot pool and wait sets, predicts each response and compares it. Uses espw_pkg.
module espw_pool_check
	import espw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	output int          fails,
	output int          pending,
	output int          checked,
	output int          misses,
	output int          rejects,
	output logic [15:0] live
);

	localparam int SLOTS = 16;
	localparam int PRIOS = 64;
	localparam logic [4:0] LIST_END = 5'd16;

	logic [4:0]  next_free [SLOTS];
	logic [4:0]  head;
	logic [15:0] in_use;
	logic [63:0] waiters [SLOTS];
	rsp_t        due_rsp [$];
	int          n_fail, n_checked, n_miss, n_reject;

	task automatic flag(input string msg);
		$display("%0t: %s", $time, msg);
		n_fail++;
	endtask

	// one command against the pool, state updated in place
	function automatic rsp_t pool_step(input cmd_t c);
		rsp_t       r;
		logic [3:0] s;
		bit         done;
		r.status   = STAT_OK;
		r.slot_out = c.event_slot;
		r.prio_out = '0;
		s          = c.event_slot;
		done       = 1'b0;
		case (c.func)
			FN_ALLOC: begin
				if (head == LIST_END) begin
					r.status   = STAT_MISS;
					r.slot_out = '0;
				end else begin
					s          = head[3:0];
					head       = next_free[s];
					in_use[s]  = 1'b1;
					waiters[s] = '0;
					r.slot_out = s;
				end
			end
			FN_FREE: begin
				if (!in_use[s]) begin
					r.status = STAT_NOT_ALLOC;
				end else begin
					waiters[s]   = '0;
					in_use[s]    = 1'b0;
					next_free[s] = head;
					head         = {1'b0, s};
				end
			end
			FN_PEND: begin
				if (!in_use[s]) r.status = STAT_NOT_ALLOC;
				else waiters[s][c.task_prio] = 1'b1;
			end
			FN_REMOVE: begin
				if (!in_use[s]) r.status = STAT_NOT_ALLOC;
				else if (!waiters[s][c.task_prio]) r.status = STAT_MISS;
				else waiters[s][c.task_prio] = 1'b0;
			end
			FN_READY: begin
				if (!in_use[s]) begin
					r.status = STAT_NOT_ALLOC;
				end else if (waiters[s] == '0) begin
					r.status = STAT_MISS;
				end else begin
					for (int p = PRIOS - 1; p >= 0; p--) begin
						if (!done && waiters[s][p]) begin
							waiters[s][p] = 1'b0;
							r.prio_out    = 6'(p);
							done          = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				next_free[i] = 5'(i + 1);
				waiters[i]   = '0;
			end
			head      = '0;
			in_use    = '0;
			due_rsp.delete();
			n_fail    = 0;
			n_checked = 0;
			n_miss    = 0;
			n_reject  = 0;
		end else begin
			// response first: it always belongs to an earlier command
			if (rsp_valid && rsp_ready) begin
				n_checked++;
				if (due_rsp.size() == 0) begin
					flag($sformatf("response with nothing expected: status %0d slot %0d prio %0d",
						rsp.status, rsp.slot_out, rsp.prio_out));
				end else begin
					want = due_rsp.pop_front();
					if (rsp.status !== want.status)
						flag($sformatf("status got %0d expected %0d", rsp.status, want.status));
					if (rsp.slot_out !== want.slot_out)
						flag($sformatf("slot_out got %0d expected %0d", rsp.slot_out,
							want.slot_out));
					if (rsp.prio_out !== want.prio_out)
						flag($sformatf("prio_out got %0d expected %0d", rsp.prio_out,
							want.prio_out));
				end
			end
			if (cmd_valid && cmd_ready) begin
				want = pool_step(cmd);
				if (want.status == STAT_MISS) n_miss++;
				if (want.status == STAT_NOT_ALLOC) n_reject++;
				due_rsp.push_back(want);
			end
		end
		fails   <= n_fail;
		pending <= due_rsp.size();
		checked <= n_checked;
		misses  <= n_miss;
		rejects <= n_reject;
		live    <= in_use;
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Top of the event slot pool testbench: clock, reset, command and response pacing.
// Depends on espw_pkg, the pool RTL and espw_pool_check.
module tb;
	import espw_pkg::*;

	localparam int ITEMS = 850;
	localparam int SEG   = 50;
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	int          fails, pending, checked, misses, rejects;
	logic [15:0] live;
	int          sent;
	int          mode;
	bit          quiet;

	event_slot_pool_with_priority_waitlists DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	espw_pool_check pool_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked),
		.misses    (misses),
		.rejects   (rejects),
		.live      (live)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// sender: random gap (none when quiet), then hold valid until the item is taken
	task automatic send(input cmd_t c);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		sent++;
	endtask

	task automatic issue(input logic [2:0] f, input logic [3:0] s, input logic [5:0] p);
		cmd_t c;
		c.func       = f;
		c.event_slot = s;
		c.task_prio  = p;
		send(c);
	endtask

	// mostly a slot that is currently allocated (stale by a few items at most)
	function automatic logic [3:0] pick_live();
		int k;
		k = $urandom_range(0, 15);
		for (int i = 0; i < 16; i++) begin
			if (live[(k + i) % 16]) return 4'((k + i) % 16);
		end
		return 4'(k);
	endfunction

	// mode 0 fills the pool, mode 1 drains it, mode 2 mixes
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   r;
		int   alloc_w;
		int   free_w;
		alloc_w = (mode == 0) ? 45 : (mode == 1) ? 5 : 15;
		free_w  = (mode == 1) ? 35 : (mode == 0) ? 3 : 10;
		r = $urandom_range(0, 99);
		if (r < alloc_w) begin
			c.func = FN_ALLOC;
		end else if (r < alloc_w + free_w) begin
			c.func = FN_FREE;
		end else if (r < 97) begin
			case ($urandom_range(0, 3))
				0, 1: c.func = FN_PEND;
				2: c.func = FN_REMOVE;
				default: c.func = FN_READY;
			endcase
		end else begin
			c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		end
		c.event_slot = (live != '0 && $urandom_range(0, 9) < 8) ? pick_live()
			: 4'($urandom_range(0, 15));
		// narrow window so removes and duplicate pends hit often
		c.task_prio = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(56, 63)) : 6'($urandom);
		return c;
	endfunction

	initial begin
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		sent      = 0;
		mode      = 2;
		quiet     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: fresh pool hands out 0 then 1
		issue(FN_ALLOC, 4'd9, 6'd0);
		issue(FN_ALLOC, 4'd0, 6'd63);
		issue(FN_PEND, 4'd0, 6'd0);
		issue(FN_PEND, 4'd0, 6'd63);
		issue(FN_PEND, 4'd0, 6'd63);     // already waiting
		issue(FN_REMOVE, 4'd0, 6'd5);    // not waiting
		issue(FN_READY, 4'd0, 6'd0);     // highest first
		issue(FN_REMOVE, 4'd0, 6'd0);
		issue(FN_READY, 4'd0, 6'd0);     // empty wait set
		issue(FN_PEND, 4'd15, 6'd1);     // slot never allocated
		issue(FN_REMOVE, 4'd15, 6'd0);
		issue(FN_READY, 4'd15, 6'd0);
		issue(FN_FREE, 4'd15, 6'd0);
		issue(FN_FREE, 4'd1, 6'd0);
		issue(FN_FREE, 4'd1, 6'd0);      // double free
		issue(FN_SPARE_LO, 4'd10, 6'd42);
		issue(3'(FN_SPARE_LO + 3'd1), 4'd5, 6'd21);
		issue(FN_SPARE_HI, 4'd15, 6'd63);
		issue(FN_PEND, 4'd0, 6'd31);
		issue(FN_FREE, 4'd0, 6'd0);      // free with a waiter still set
		issue(FN_ALLOC, 4'd0, 6'd0);
		issue(FN_READY, 4'd0, 6'd0);     // set was cleared on free

		for (int n = 0; n < ITEMS; n++) begin
			if (n % SEG == 0) begin
				mode  = $urandom_range(0, 2);
				quiet = ($urandom_range(0, 3) == 0);
			end
			send(random_cmd());
		end
		cmd_valid <= 1'b0;
		quiet = 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);

		$display("%0d commands sent, %0d responses checked", sent, checked);
		$display("%0d miss responses (empty pool, absent waiter), %0d unallocated-slot rejects",
			misses, rejects);
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> event_slot_pool_with_priority_waitlists.f
rtl/espw_pkg.sv
rtl/espw_ram.sv
rtl/event_slot_pool_with_priority_waitlists.sv
rtl/espw_checker.sv
verif/espw_pool_check.sv
verif/tb.sv
